### src/fcs_pkg.sv
package fcs_pkg;

    localparam int IN_DIM    = 3;
    localparam int N_OUT     = 8;
    localparam int CHAN_W    = 16;
    localparam int RECIP_W   = 16;
    localparam int WEIGHT_W  = 24;
    localparam int CH_W      = $clog2(IN_DIM);
    localparam int OUT_W     = $clog2(N_OUT);
    localparam int EMPTY_W   = $clog2(N_OUT + 1);
    // Remainder can drop by up to N_OUT full-scale shares; keep a sign bit on top.
    localparam int REM_W     = CHAN_W + OUT_W + 1;
    localparam int DIV_STEPS = CHAN_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;
    localparam int LANES     = CFG_W / RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_ONE = 16'h0100;

    localparam logic [CFG_IDX_W-1:0] CFG_MEMBERSHIP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP_HIGH  = 2'd2;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_NO_EMPTY = 2'd1,
        ERR_NEG_REM  = 2'd2
    } err_t;

    typedef struct packed {
        logic            load;
        logic            sort;
        logic            scan_init;
        logic            scan_step;
        logic            set_err;
        err_t            err_code;
        logic            div_start;
        logic            div_step;
        logic            fill;
        logic            out_load;
        logic [CH_W-1:0] ch_idx;
        logic [CNT_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic empty_zero;
        logic rem_neg;
        logic out_free;
    } status_t;

endpackage

### src/fcs_ctrl.sv
module fcs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  fcs_pkg::status_t status,
    output fcs_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT,
        S_SCAN_INIT,
        S_SCAN,
        S_CHECK,
        S_DIV,
        S_FILL,
        S_OUT
    } state_t;

    state_t                       state_reg, state_next;
    logic [fcs_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [fcs_pkg::CH_W-1:0]     ch_reg, ch_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ch_next      = ch_reg;
        cmd          = '0;
        cmd.err_code = fcs_pkg::ERR_OK;
        cmd.ch_idx   = ch_reg;
        cmd.idx      = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SORT;
                end
            end
            S_SORT:
            begin
                cmd.sort   = 1'b1;
                ch_next    = '0;
                state_next = S_SCAN_INIT;
            end
            S_SCAN_INIT:
            begin
                cmd.scan_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (cnt_reg == fcs_pkg::CNT_W'(fcs_pkg::N_OUT - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_CHECK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_CHECK:
            begin
                cnt_next = '0;
                if (status.empty_zero)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = fcs_pkg::ERR_NO_EMPTY;
                    state_next   = S_OUT;
                end
                else if (status.rem_neg)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = fcs_pkg::ERR_NEG_REM;
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == fcs_pkg::CNT_W'(fcs_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FILL:
            begin
                cmd.fill = 1'b1;
                cnt_next = '0;
                if (ch_reg == fcs_pkg::CH_W'(fcs_pkg::IN_DIM - 1))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = S_SCAN_INIT;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (cnt_reg == fcs_pkg::CNT_W'(fcs_pkg::N_OUT - 1))
                    begin
                        cnt_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ch_reg    <= ch_next;
        end
    end

endmodule

### src/fcs_datapath.sv
module fcs_datapath (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic [fcs_pkg::IN_DIM-1:0][fcs_pkg::CHAN_W-1:0]  chan_vals,
    input  logic                                             cfg_valid,
    input  logic [fcs_pkg::CFG_IDX_W-1:0]                    cfg_index,
    input  logic [fcs_pkg::CFG_W-1:0]                        cfg_data,
    input  fcs_pkg::cmd_t                                    cmd,
    output fcs_pkg::status_t                                 status,
    input  logic                                             out_stall,
    output logic                                             out_valid,
    output logic [fcs_pkg::OUT_W-1:0]                        out_class,
    output logic [fcs_pkg::WEIGHT_W-1:0]                     weight,
    output logic [1:0]                                       error,
    output logic                                             last
);

    // Configuration
    logic [fcs_pkg::IN_DIM-1:0][fcs_pkg::N_OUT-1:0]   membership_reg;
    logic [fcs_pkg::N_OUT-1:0][fcs_pkg::RECIP_W-1:0]  recip_reg;

    // Per-item working state
    logic [fcs_pkg::CHAN_W-1:0]   val_reg   [fcs_pkg::IN_DIM];
    logic [fcs_pkg::CH_W-1:0]     order_reg [fcs_pkg::IN_DIM];
    logic [fcs_pkg::CH_W-1:0]     order_next [fcs_pkg::IN_DIM];
    logic [fcs_pkg::CH_W-1:0]     rank      [fcs_pkg::IN_DIM];
    logic [fcs_pkg::CHAN_W-1:0]   share_reg [fcs_pkg::N_OUT];
    logic [fcs_pkg::N_OUT-1:0]    filled_reg;
    logic [fcs_pkg::REM_W-1:0]    rem_reg;
    logic [fcs_pkg::EMPTY_W-1:0]  empty_reg;
    logic [fcs_pkg::CHAN_W-1:0]   quot_reg;
    logic [fcs_pkg::EMPTY_W-1:0]  part_reg;
    fcs_pkg::err_t                err_reg;

    // Output register
    logic                         out_valid_reg;
    logic [fcs_pkg::OUT_W-1:0]    out_index_reg;
    logic [fcs_pkg::WEIGHT_W-1:0] out_weight_reg;
    fcs_pkg::err_t                out_err_reg;
    logic                         out_last_reg;

    logic [fcs_pkg::CH_W-1:0]     cur_ch;
    logic [fcs_pkg::N_OUT-1:0]    row;
    logic [fcs_pkg::OUT_W-1:0]    o_sel;
    logic [fcs_pkg::EMPTY_W:0]    part_sh;
    logic                         part_ge;
    logic [fcs_pkg::CHAN_W+fcs_pkg::RECIP_W-1:0] product;
    logic [fcs_pkg::WEIGHT_W-1:0] weight_val;

    assign cur_ch = order_reg[cmd.ch_idx];
    assign row    = membership_reg[cur_ch];
    assign o_sel  = cmd.idx[fcs_pkg::OUT_W-1:0];

    // Stable ranking: lower value first, ties to lower channel index
    always_comb
    begin
        for (int i = 0; i < fcs_pkg::IN_DIM; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < fcs_pkg::IN_DIM; j++)
            begin
                if (j != i)
                begin
                    if ((val_reg[j] < val_reg[i]) || ((val_reg[j] == val_reg[i]) && (j < i)))
                    begin
                        rank[i] = rank[i] + 1'b1;
                    end
                end
            end
        end
        for (int i = 0; i < fcs_pkg::IN_DIM; i++)
        begin
            order_next[i] = order_reg[i];
        end
        for (int i = 0; i < fcs_pkg::IN_DIM; i++)
        begin
            order_next[rank[i]] = fcs_pkg::CH_W'(i);
        end
    end

    // One restoring divide step; partial remainder stays below the divisor
    assign part_sh = {part_reg, quot_reg[fcs_pkg::CHAN_W-1]};
    assign part_ge = (part_sh >= {1'b0, empty_reg});

    assign status.empty_zero = (empty_reg == '0);
    assign status.rem_neg    = rem_reg[fcs_pkg::REM_W-1];
    assign status.out_free   = !out_valid_reg || !out_stall;

    // 16x16 product shifted down by 8 always fits the 24-bit weight
    assign product    = share_reg[o_sel] * recip_reg[o_sel];
    assign weight_val = (err_reg == fcs_pkg::ERR_OK && filled_reg[o_sel])
                        ? product[fcs_pkg::CHAN_W+fcs_pkg::RECIP_W-1:8] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            membership_reg <= '0;
            for (int k = 0; k < fcs_pkg::N_OUT; k++)
            begin
                recip_reg[k] <= fcs_pkg::RECIP_ONE;
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fcs_pkg::CFG_MEMBERSHIP:
                    membership_reg <= cfg_data[fcs_pkg::IN_DIM*fcs_pkg::N_OUT-1:0];
                fcs_pkg::CFG_RECIP_LOW:
                    recip_reg[fcs_pkg::LANES-1:0] <= cfg_data;
                fcs_pkg::CFG_RECIP_HIGH:
                    recip_reg[fcs_pkg::N_OUT-1:fcs_pkg::LANES] <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
            err_reg    <= fcs_pkg::ERR_OK;
        end
        else
        begin
            if (cmd.load)
            begin
                filled_reg <= '0;
                err_reg    <= fcs_pkg::ERR_OK;
            end
            if (cmd.set_err)
            begin
                err_reg <= cmd.err_code;
            end
            if (cmd.fill)
            begin
                filled_reg <= filled_reg | row;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < fcs_pkg::IN_DIM; i++)
            begin
                val_reg[i] <= chan_vals[i];
            end
        end
        if (cmd.sort)
        begin
            for (int i = 0; i < fcs_pkg::IN_DIM; i++)
            begin
                order_reg[i] <= order_next[i];
            end
        end
        if (cmd.scan_init)
        begin
            rem_reg   <= fcs_pkg::REM_W'(val_reg[cur_ch]);
            empty_reg <= '0;
        end
        if (cmd.scan_step && row[o_sel])
        begin
            if (filled_reg[o_sel])
            begin
                rem_reg <= rem_reg - fcs_pkg::REM_W'(share_reg[o_sel]);
            end
            else
            begin
                empty_reg <= empty_reg + 1'b1;
            end
        end
        if (cmd.div_start)
        begin
            quot_reg <= rem_reg[fcs_pkg::CHAN_W-1:0];
            part_reg <= '0;
        end
        if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[fcs_pkg::CHAN_W-2:0], part_ge};
            part_reg <= part_ge ? fcs_pkg::EMPTY_W'(part_sh - {1'b0, empty_reg})
                                : part_sh[fcs_pkg::EMPTY_W-1:0];
        end
        if (cmd.fill)
        begin
            for (int k = 0; k < fcs_pkg::N_OUT; k++)
            begin
                if (row[k] && !filled_reg[k])
                begin
                    share_reg[k] <= quot_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_index_reg  <= o_sel;
            out_weight_reg <= weight_val;
            out_err_reg    <= err_reg;
            out_last_reg   <= (o_sel == fcs_pkg::OUT_W'(fcs_pkg::N_OUT - 1));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_class = out_index_reg;
    assign weight    = out_weight_reg;
    assign error     = out_err_reg;
    assign last      = out_last_reg;

endmodule

### src/fair_color_split.sv
// Results of an accepted color follow one per cycle while the output side does not stall
// (error exits finish sooner). A new color is taken only once the controller is idle again,
// after the last result of the previous one; the pace is set by the output scan per channel
// and the 16-step bit-serial divider in the datapath.
// Reset: asynchronous active low; membership clears, reciprocals return to 1.0,
// controller returns to idle and the output register empties.
module fair_color_split (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input items
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [fcs_pkg::CHAN_W-1:0]        channel_0,
    input  logic [fcs_pkg::CHAN_W-1:0]        channel_1,
    input  logic [fcs_pkg::CHAN_W-1:0]        channel_2,
    // Result items
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [fcs_pkg::OUT_W-1:0]         out_class,
    output logic [fcs_pkg::WEIGHT_W-1:0]      weight,
    output logic [1:0]                        error,
    output logic                              last,
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fcs_pkg::CFG_W-1:0]         cfg_data
);

    logic [fcs_pkg::IN_DIM-1:0][fcs_pkg::CHAN_W-1:0] chan_vals;
    fcs_pkg::cmd_t    cmd;
    fcs_pkg::status_t status;

    // Registers are always writable; write them only while no item is in flight.
    assign cfg_ready = 1'b1;

    // Gather the channels into one vector for the datapath.
    assign chan_vals[0] = channel_0;
    assign chan_vals[1] = channel_1;
    assign chan_vals[2] = channel_2;

    // Controller: sort, then per channel scan the outputs, check, divide, fill (a failed check
    // skips to the drain); finally drain one result per output into the output register.
    fcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: configuration registers, channel ranking, remainder accumulator,
    // restoring divider, per-output shares and the reciprocal multiplier.
    fcs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .chan_vals    (chan_vals),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .out_class    (out_class),
        .weight       (weight),
        .error        (error),
        .last         (last)
    );

endmodule
